FILE: rtl/lpzd_pkg.sv
// ----------------------------------------------------------------------------
// lpzd_pkg
// Shared types and constants for the length-prefixed zero-marker deframer.
// ----------------------------------------------------------------------------
package lpzd_pkg;

    // Field and register widths
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned KIND_W  = 3;
    localparam int unsigned CFG_IDX_W = 2;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 2'd1;

    // Register reset values
    localparam logic [LEN_W-1:0] MIN_LEN_RST = 16'd33;
    localparam logic [LEN_W-1:0] MAX_LEN_RST = 16'hFFFF;

    // Deframer phase
    typedef enum logic [1:0] {
        PH_LEN_LO = 2'd0,
        PH_LEN_HI = 2'd1,
        PH_BODY   = 2'd2,
        PH_HUNT   = 2'd3
    } t_phase;

    // Result kind codes
    typedef enum logic [KIND_W-1:0] {
        K_PAYLOAD = 3'd0,
        K_GOOD    = 3'd1,
        K_SMALL   = 3'd2,
        K_LARGE   = 3'd3,
        K_NOMARK  = 3'd4,
        K_RESYNC  = 3'd5
    } t_kind;

endpackage

FILE: rtl/lpzd_in_stage.sv
// ----------------------------------------------------------------------------
// lpzd_in_stage
// Input register: holds one received byte until the deframing stage takes it.
// ----------------------------------------------------------------------------
module lpzd_in_stage (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [lpzd_pkg::BYTE_W-1:0] i_rx_byte,
    input  logic                        i_adv,
    output logic                        o_vld,
    output logic [lpzd_pkg::BYTE_W-1:0] o_byte
);
    import lpzd_pkg::*;

    logic              r_vld;
    logic [BYTE_W-1:0] r_byte;
    logic              w_ready;

    // Register is free when empty or being drained this cycle
    assign w_ready = !r_vld || i_adv;
    assign o_stall = !w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready && i_valid) begin
            r_byte <= i_rx_byte;
        end
    end

    assign o_vld  = r_vld;
    assign o_byte = r_byte;

endmodule

FILE: rtl/lpzd_core.sv
// ----------------------------------------------------------------------------
// lpzd_core
// Deframing state machine, length limit registers and the result register.
// ----------------------------------------------------------------------------
module lpzd_core #(
    parameter int unsigned MARKER_LEN = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // byte from the input register
    input  logic                           i_vld,
    input  logic [lpzd_pkg::BYTE_W-1:0]    i_byte,
    output logic                           o_adv,
    // configuration writes
    input  logic                           i_cfg_we,
    input  logic [lpzd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lpzd_pkg::LEN_W-1:0]     i_cfg_data,
    // result channel
    output logic                           o_valid,
    input  logic                           i_stall,
    output lpzd_pkg::t_kind                o_result_kind,
    output logic [lpzd_pkg::BYTE_W-1:0]    o_data_byte
);
    import lpzd_pkg::*;

    localparam int unsigned RUN_W = $clog2(MARKER_LEN + 1);
    localparam logic [LEN_W-1:0]   MARKER_LEN_L = LEN_W'(MARKER_LEN);
    localparam logic [RUN_W:0]     MARKER_LEN_R = (RUN_W + 1)'(MARKER_LEN);

    // Length limit registers
    logic [LEN_W-1:0] r_min_len;
    logic [LEN_W-1:0] r_max_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= MIN_LEN_RST;
            r_max_len <= MAX_LEN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MIN_LEN: r_min_len <= i_cfg_data;
                CFG_MAX_LEN: r_max_len <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Deframer state
    t_phase            r_phase,   n_phase;
    logic [BYTE_W-1:0] r_len_lo,  n_len_lo;
    logic [LEN_W-1:0]  r_frm_len, n_frm_len;
    logic [LEN_W-1:0]  r_pos,     n_pos;
    logic [RUN_W-1:0]  r_run,     n_run;
    logic              r_mrk_ok,  n_mrk_ok;

    // Result register
    logic              r_out_valid;
    t_kind             r_out_kind;
    logic [BYTE_W-1:0] r_out_data;

    logic              w_emit;
    t_kind             w_kind;
    logic [BYTE_W-1:0] w_data;
    logic              w_out_free;
    logic [LEN_W-1:0]  w_len;
    logic [LEN_W-1:0]  w_mrk_start;
    logic [LEN_W:0]    w_pos_inc;
    logic [RUN_W:0]    w_run_inc;
    logic              w_byte_zero;

    // Take the next byte whenever the result register can hold a result
    assign w_out_free = !r_out_valid || !i_stall;
    assign o_adv      = i_vld && w_out_free;

    assign w_len       = {i_byte, r_len_lo};
    assign w_mrk_start = r_frm_len - MARKER_LEN_L;
    assign w_pos_inc   = {1'b0, r_pos} + 1'b1;
    assign w_byte_zero = (i_byte == '0);
    assign w_run_inc   = w_byte_zero ? ({1'b0, r_run} + 1'b1) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_LEN_LO;
            r_len_lo  <= '0;
            r_frm_len <= '0;
            r_pos     <= '0;
            r_run     <= '0;
            r_mrk_ok  <= 1'b1;
        end else begin
            r_phase   <= n_phase;
            r_len_lo  <= n_len_lo;
            r_frm_len <= n_frm_len;
            r_pos     <= n_pos;
            r_run     <= n_run;
            r_mrk_ok  <= n_mrk_ok;
        end
    end

    // Next state and result for the byte being taken
    always_comb begin
        n_phase   = r_phase;
        n_len_lo  = r_len_lo;
        n_frm_len = r_frm_len;
        n_pos     = r_pos;
        n_run     = r_run;
        n_mrk_ok  = r_mrk_ok;
        w_emit    = 1'b0;
        w_kind    = K_PAYLOAD;
        w_data    = '0;
        if (o_adv) begin
            unique case (r_phase)
                PH_LEN_LO: begin
                    n_len_lo = i_byte;
                    n_phase  = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    // too-short check wins over too-long
                    if (w_len < r_min_len || w_len < MARKER_LEN_L) begin
                        w_emit  = 1'b1;
                        w_kind  = K_SMALL;
                        n_phase = PH_HUNT;
                        n_run   = '0;
                    end else if (w_len > r_max_len) begin
                        w_emit  = 1'b1;
                        w_kind  = K_LARGE;
                        n_phase = PH_HUNT;
                        n_run   = '0;
                    end else begin
                        n_frm_len = w_len;
                        n_pos     = '0;
                        n_mrk_ok  = 1'b1;
                        n_phase   = PH_BODY;
                    end
                end
                PH_BODY: begin
                    n_pos = w_pos_inc[LEN_W-1:0];
                    if (r_pos < w_mrk_start) begin
                        w_emit = 1'b1;
                        w_kind = K_PAYLOAD;
                        w_data = i_byte;
                    end else begin
                        n_mrk_ok = r_mrk_ok && w_byte_zero;
                        // last body byte closes the frame
                        if (w_pos_inc >= {1'b0, r_frm_len}) begin
                            w_emit = 1'b1;
                            if (n_mrk_ok) begin
                                w_kind  = K_GOOD;
                                n_phase = PH_LEN_LO;
                            end else begin
                                w_kind  = K_NOMARK;
                                n_phase = PH_HUNT;
                                n_run   = '0;
                            end
                        end
                    end
                end
                PH_HUNT: begin
                    if (w_run_inc >= MARKER_LEN_R) begin
                        w_emit  = 1'b1;
                        w_kind  = K_RESYNC;
                        n_run   = '0;
                        n_phase = PH_LEN_LO;
                    end else begin
                        n_run = w_run_inc[RUN_W-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // Result register, reloaded whenever it is empty or being taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_emit) begin
            r_out_kind <= w_kind;
            r_out_data <= w_data;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_result_kind = r_out_kind;
    assign o_data_byte   = r_out_data;

endmodule

FILE: rtl/length_prefixed_zero_marker_deframer_top.sv
// ----------------------------------------------------------------------------
// length_prefixed_zero_marker_deframer_top
// Deframes length-prefixed frames that end in a run of zero marker bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall / i_rx_byte) carries one received byte
//   per request. Each frame is a 16-bit little-endian length followed by that
//   many body bytes, of which the last MARKER_LEN must be zero.
//   Output channel (o_valid / i_stall / o_result_kind / o_data_byte) carries
//   payload bytes, then one frame-good or marker-missing request per frame.
//   Length errors and a missing marker start a hunt for MARKER_LEN zero bytes,
//   which ends with a resync-found request.
//   In-range length bytes and marker bytes other than the last give no request.
// Timing:
//   One byte per cycle sustained while i_stall stays low. A taken byte is
//   held in the input register, then decoded into the result register,
//   which drives the outputs. Both registers drain and refill in the same
//   cycle.
// Stall and reset:
//   A stalled result holds; the input register fills and then o_stall rises.
//   Reset clears both registers, returns to awaiting a length and loads the
//   limits with 33 and 65535. Limits must be written while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module length_prefixed_zero_marker_deframer_top #(
    parameter int unsigned MARKER_LEN = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // received byte requests
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [lpzd_pkg::BYTE_W-1:0]    i_rx_byte,
    // configuration writes
    input  logic                           i_cfg_we,
    input  logic [lpzd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lpzd_pkg::LEN_W-1:0]     i_cfg_data,
    // result requests
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [lpzd_pkg::KIND_W-1:0]    o_result_kind,
    output logic [lpzd_pkg::BYTE_W-1:0]    o_data_byte
);
    import lpzd_pkg::*;

    logic              w_vld;
    logic [BYTE_W-1:0] w_byte;
    logic              w_adv;
    t_kind             w_kind;

    // Input register
    lpzd_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_rx_byte (i_rx_byte),
        .i_adv     (w_adv),
        .o_vld     (w_vld),
        .o_byte    (w_byte)
    );

    // Deframing stage and result register
    lpzd_core #(
        .MARKER_LEN (MARKER_LEN)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_vld         (w_vld),
        .i_byte        (w_byte),
        .o_adv         (w_adv),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_result_kind (w_kind),
        .o_data_byte   (o_data_byte)
    );

    assign o_result_kind = w_kind;

endmodule

FILE: rtl/lpzd_chk.sv
// ----------------------------------------------------------------------------
// lpzd_chk
// Port-level checks for the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module lpzd_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_stall,
    input logic                           o_valid,
    input logic                           i_stall,
    input logic [lpzd_pkg::KIND_W-1:0]    o_result_kind,
    input logic [lpzd_pkg::BYTE_W-1:0]    o_data_byte
);
    import lpzd_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_kind) && $stable(o_data_byte))
        else $error("stalled result changed");

    // Only payload requests carry data
    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_kind != K_PAYLOAD |-> o_data_byte == '0)
        else $error("non-payload result with nonzero data");

    // No result code beyond resync found
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result_kind == K_PAYLOAD || o_result_kind == K_GOOD ||
                     o_result_kind == K_SMALL || o_result_kind == K_LARGE ||
                     o_result_kind == K_NOMARK || o_result_kind == K_RESYNC))
        else $error("result code out of range");

    // Reset empties the result register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Input side cannot stall while the result side is free
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with empty result register");

endmodule

bind length_prefixed_zero_marker_deframer_top lpzd_chk u_lpzd_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_result_kind (o_result_kind),
    .o_data_byte   (o_data_byte)
);
